@@ sv/websocket_frame_deframer_unit_assert.svh @@
// Assertion macros used by the deframer queue.
// Each expects clk and rst_n in the enclosing scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define WSD_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define WSD_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/wsd_pkg.sv @@
package wsd_pkg;

  localparam int LEN_WIDTH_DEF = 64;
  localparam int Q_DEPTH_DEF   = 2;
  localparam int OUT_LEN_W     = 64;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RK_HEADER  = 2'd0,
    RK_PAYLOAD = 2'd1,
    RK_ERROR   = 2'd2
  } rkind_t;

  localparam logic ERR_OPCODE = 1'b0;
  localparam logic ERR_MASK   = 1'b1;

  localparam logic IN_BYTE    = 1'b0;
  localparam logic IN_RESTART = 1'b1;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'ha;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef struct packed {
    rkind_t                 kind;
    logic                   fin;
    logic [3:0]             opcode;
    logic [OUT_LEN_W-1:0]   length;
    logic [7:0]             data;
    logic [7:0]             key_byte;
    logic                   last;
    logic                   err;
  } wsd_cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } wsd_qctl_t;

  function automatic logic opcode_allowed(logic [3:0] op);
    logic ok;
    case (op)
      OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ sv/wsd_if.sv @@
interface wsd_in_if
  import wsd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface wsd_out_if
  import wsd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic                 fin_flag;
  logic [3:0]           frame_opcode;
  logic [OUT_LEN_W-1:0] frame_length;
  logic [7:0]           payload_byte;
  logic                 last_flag;
  logic                 error_code;

  modport source (output valid, output result_kind, output fin_flag, output frame_opcode,
                  output frame_length, output payload_byte, output last_flag,
                  output error_code, input ready);
  modport sink   (input valid, input result_kind, input fin_flag, input frame_opcode,
                  input frame_length, input payload_byte, input last_flag,
                  input error_code, output ready);
endinterface

@@ sv/wsd_front.sv @@
module wsd_front
  import wsd_pkg::*;
#(
  parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_kind,
  input  logic [7:0] in_data,
  input  logic      q_full,
  output logic      q_push,
  output wsd_cmd_t  q_cmd
);

  phase_t               phase_r, phase_nxt;
  logic                 fin_r, fin_nxt;
  logic [3:0]           op_r, op_nxt;
  logic [3:0]           ext_left_r, ext_left_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [2:0]           key_left_r, key_left_nxt;
  logic [LEN_WIDTH-1:0] idx_r, idx_nxt;

  logic                 beat;
  logic                 byte_beat;
  logic [LEN_WIDTH-1:0] idx_inc;
  logic                 pay_last;
  logic [3:0]           ext_dec;
  logic [2:0]           key_dec;
  logic [7:0]           key_sel;

  assign in_ready  = !q_full;
  assign beat      = in_valid && in_ready;
  assign byte_beat = beat && (in_kind == IN_BYTE);
  assign idx_inc   = idx_r + LEN_WIDTH'(1);
  assign pay_last  = (idx_inc >= len_r);
  assign ext_dec   = ext_left_r - 4'd1;
  assign key_dec   = key_left_r - 3'd1;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (beat && in_kind == IN_RESTART) begin
      phase_nxt = PH_HDR0;
    end else if (byte_beat) begin
      case (phase_r)
        PH_HDR0:    phase_nxt = opcode_allowed(in_data[3:0]) ? PH_HDR1 : PH_DROP;
        PH_HDR1: begin
          if (!in_data[7]) begin
            phase_nxt = PH_DROP;
          end else if (in_data[6:0] == LEN7_EXT16 || in_data[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_EXTLEN;
          end else begin
            phase_nxt = PH_KEY;
          end
        end
        PH_EXTLEN:  phase_nxt = (ext_dec == 4'd0) ? PH_KEY : PH_EXTLEN;
        PH_KEY: begin
          if (key_dec == 3'd0) begin
            phase_nxt = (len_r == '0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: phase_nxt = pay_last ? PH_HDR0 : PH_PAYLOAD;
        default:    phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    fin_nxt      = fin_r;
    op_nxt       = op_r;
    ext_left_nxt = ext_left_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    idx_nxt      = idx_r;
    q_push       = 1'b0;
    q_cmd.kind     = RK_HEADER;
    q_cmd.fin      = fin_r;
    q_cmd.opcode   = op_r;
    q_cmd.length   = '0;
    q_cmd.data     = 8'd0;
    q_cmd.key_byte = 8'd0;
    q_cmd.last     = 1'b0;
    q_cmd.err      = 1'b0;
    if (beat && in_kind == IN_RESTART) begin
      fin_nxt      = 1'b0;
      op_nxt       = 4'd0;
      ext_left_nxt = 4'd0;
      len_nxt      = '0;
      key_nxt      = 32'd0;
      key_left_nxt = 3'd0;
      idx_nxt      = '0;
    end else if (byte_beat) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt = in_data[7];
          op_nxt  = in_data[3:0];
          if (!opcode_allowed(in_data[3:0])) begin
            q_push       = 1'b1;
            q_cmd.kind   = RK_ERROR;
            q_cmd.fin    = in_data[7];
            q_cmd.opcode = in_data[3:0];
            q_cmd.err    = ERR_OPCODE;
          end
        end
        PH_HDR1: begin
          if (!in_data[7]) begin
            q_push     = 1'b1;
            q_cmd.kind = RK_ERROR;
            q_cmd.err  = ERR_MASK;
          end else begin
            key_nxt      = 32'd0;
            key_left_nxt = KEY_BYTES;
            if (in_data[6:0] == LEN7_EXT16) begin
              len_nxt      = '0;
              ext_left_nxt = EXT16_BYTES;
            end else if (in_data[6:0] == LEN7_EXT64) begin
              len_nxt      = '0;
              ext_left_nxt = EXT64_BYTES;
            end else begin
              len_nxt = LEN_WIDTH'(in_data[6:0]);
            end
          end
        end
        PH_EXTLEN: begin
          len_nxt      = {len_r[LEN_WIDTH-9:0], in_data};
          ext_left_nxt = ext_dec;
        end
        PH_KEY: begin
          key_nxt      = {key_r[23:0], in_data};
          key_left_nxt = key_dec;
          if (key_dec == 3'd0) begin
            idx_nxt      = '0;
            q_push       = 1'b1;
            q_cmd.kind   = RK_HEADER;
            q_cmd.length = OUT_LEN_W'(len_r);
            q_cmd.last   = (len_r == '0);
          end
        end
        PH_PAYLOAD: begin
          idx_nxt        = idx_inc;
          q_push         = 1'b1;
          q_cmd.kind     = RK_PAYLOAD;
          q_cmd.length   = OUT_LEN_W'(len_r);
          q_cmd.data     = in_data;
          q_cmd.key_byte = key_sel;
          q_cmd.last     = pay_last;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      fin_r      <= 1'b0;
      op_r       <= 4'd0;
      ext_left_r <= 4'd0;
      len_r      <= '0;
      key_r      <= 32'd0;
      key_left_r <= 3'd0;
      idx_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      op_r       <= op_nxt;
      ext_left_r <= ext_left_nxt;
      len_r      <= len_nxt;
      key_r      <= key_nxt;
      key_left_r <= key_left_nxt;
      idx_r      <= idx_nxt;
    end
  end

endmodule

@@ sv/wsd_queue.sv @@
`include "websocket_frame_deframer_unit_assert.svh"

module wsd_queue
  import wsd_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wsd_cmd_t  push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output wsd_cmd_t  head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsd_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  wsd_qctl_t          ctl;

  assign ctl.push   = push;
  assign ctl.full   = (count_r == CNT_W'(DEPTH));
  assign full       = ctl.full;
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({ctl.push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WSD_ASSERT_NOW(a_no_push_full, ctl.full, !ctl.push, "push into full queue")
  `WSD_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "pop from empty queue")
  `WSD_ASSERT_NEXT(a_push_fills, ctl.push && !pop, count_r != '0, "push lost")
  `WSD_ASSERT_NOW(a_ptrs_match, count_r == '0 || ctl.full, wr_ptr_r == rd_ptr_r,
                  "pointers disagree with fill count")

endmodule

@@ sv/wsd_back.sv @@
module wsd_back
  import wsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  wsd_cmd_t           head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic               out_fin_flag,
  output logic [3:0]         out_frame_opcode,
  output logic [OUT_LEN_W-1:0] out_frame_length,
  output logic [7:0]         out_payload_byte,
  output logic               out_last_flag,
  output logic               out_error_code
);

  logic                 valid_r, valid_nxt;
  logic [1:0]           kind_r;
  logic                 fin_r;
  logic [3:0]           op_r;
  logic [OUT_LEN_W-1:0] len_r;
  logic [7:0]           byte_r;
  logic                 last_r;
  logic                 err_r;

  assign pop = head_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head_cmd.kind;
      fin_r  <= head_cmd.fin;
      op_r   <= head_cmd.opcode;
      len_r  <= head_cmd.length;
      byte_r <= head_cmd.data ^ head_cmd.key_byte;
      last_r <= head_cmd.last;
      err_r  <= head_cmd.err;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_kind  = kind_r;
  assign out_fin_flag     = fin_r;
  assign out_frame_opcode = op_r;
  assign out_frame_length = len_r;
  assign out_payload_byte = byte_r;
  assign out_last_flag    = last_r;
  assign out_error_code   = err_r;

endmodule

@@ sv/websocket_frame_deframer_unit.sv @@
// Server-side WebSocket frame decoder taking one received byte per beat and
// sustaining one beat per cycle unless the queue is full: header, extended
// length and masking key are parsed by a per-byte state machine, and each
// header, payload or error result passes through a queue (two entries by
// default) into a registered output stage that applies the key. With the output
// stalled the input keeps accepting until the queue fills. Restart beats and
// error-free header bytes before the last key byte give no result; the last key
// byte gives the header result. After an error bytes are dropped until restart.
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int LEN_WIDTH   = LEN_WIDTH_DEF,
  parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  wsd_in_if.sink         in_chan,
  wsd_out_if.source      out_chan
);

  wsd_cmd_t q_in_cmd;
  wsd_cmd_t q_head_cmd;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;

  wsd_front #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_kind  (in_chan.kind),
    .in_data  (in_chan.data_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in_cmd)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  wsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_cmd         (q_head_cmd),
    .pop              (q_pop),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_result_kind  (out_chan.result_kind),
    .out_fin_flag     (out_chan.fin_flag),
    .out_frame_opcode (out_chan.frame_opcode),
    .out_frame_length (out_chan.frame_length),
    .out_payload_byte (out_chan.payload_byte),
    .out_last_flag    (out_chan.last_flag),
    .out_error_code   (out_chan.error_code)
  );

endmodule
